>>> rtl/frame_to_dropframe_timecode_top_macros.svh
`ifndef FRAME_TO_DROPFRAME_TIMECODE_TOP_MACROS_SVH
`define FRAME_TO_DROPFRAME_TIMECODE_TOP_MACROS_SVH

// same-cycle check
`define FTDT_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle check
`define FTDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ftdt_pkg.sv
package ftdt_pkg;

   localparam int MAX_NOMINAL_FPS_DEF = 240;
   localparam int FRAME_BITS_DEF      = 40;

   localparam int NUM_W   = 18;
   localparam int DEN_W   = 14;
   localparam int START_W = 5;

   localparam int NUM_MAX     = 240000;
   localparam int DEN_MAX     = 10000;
   localparam int NUM_RESET   = 30000;
   localparam int DEN_RESET   = 1001;
   localparam int START_RESET = 0;
   localparam int NUM_DROP30  = 30000;
   localparam int NUM_DROP60  = 60000;
   localparam int DEN_DROP    = 1001;
   localparam int DPM_30      = 2;
   localparam int DPM_60      = 4;
   localparam int DROP_FPS_MAX = 60;

   localparam int SEC_PER_MIN   = 60;
   localparam int SEC_PER_TEN   = 600;
   localparam int SEC_PER_HOUR  = 3600;
   localparam int SEC_PER_DAY   = 86400;
   localparam int HOURS_PER_DAY = 24;
   localparam int DROPS_PER_TEN  = 9;
   localparam int DROPS_PER_HOUR = 54;
   localparam int START_HOUR_MAX = 31;

   localparam int RECIP_HOUR_SH = 22;
   localparam int RECIP_HOUR    = (1 << RECIP_HOUR_SH) / SEC_PER_HOUR;
   localparam int RECIP_MIN_SH  = 16;
   localparam int RECIP_MIN     = (1 << RECIP_MIN_SH) / SEC_PER_MIN;

   localparam int TEN_QW = 8;   // ten-minute blocks in a day: < 256
   localparam int MIN_QW = 4;   // minutes in a block: < 16
   localparam int SEC_QW = 17;  // seconds in a day: < 2^17
   localparam int HR_W   = 6;
   localparam int SR_W   = 12;
   localparam int MN_W   = 6;

   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd2;

   typedef struct packed {
      logic ok;
      logic drop;
      logic quad;   // four labels dropped per minute
   } rate_flags_type;

   function automatic int fps_cap(input int maxf);
      return (maxf > DROP_FPS_MAX) ? maxf : DROP_FPS_MAX;
   endfunction

   function automatic int nom_width(input int maxf);
      return $clog2(maxf + 1);
   endfunction

   function automatic int day_width(input int maxf);
      return $clog2(fps_cap(maxf) * SEC_PER_DAY + 1);
   endfunction

   function automatic int hour_width(input int maxf);
      return $clog2(fps_cap(maxf) * SEC_PER_HOUR + 1);
   endfunction

   function automatic int start_width(input int maxf);
      return $clog2(START_HOUR_MAX * fps_cap(maxf) * SEC_PER_HOUR + 1);
   endfunction

   function automatic int ten_width(input int maxf);
      return $clog2(fps_cap(maxf) * SEC_PER_TEN + 1);
   endfunction

   function automatic int min_width(input int maxf);
      return $clog2(fps_cap(maxf) * SEC_PER_MIN + 1);
   endfunction

endpackage

>>> rtl/ftdt_cfg.sv
module ftdt_cfg #(
   parameter int MAX_NOMINAL_FPS = ftdt_pkg::MAX_NOMINAL_FPS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [ftdt_pkg::CSR_IDX_W-1:0]                  csr_index,
   input  logic [ftdt_pkg::NUM_W-1:0]                      csr_data,
   input  logic                                            pipe_empty,
   output logic                                            busy,
   output ftdt_pkg::rate_flags_type                        flags,
   output logic [ftdt_pkg::nom_width(MAX_NOMINAL_FPS)-1:0]   nom,
   output logic [ftdt_pkg::min_width(MAX_NOMINAL_FPS)-1:0]   per_min,
   output logic [ftdt_pkg::ten_width(MAX_NOMINAL_FPS)-1:0]   per_ten,
   output logic [ftdt_pkg::day_width(MAX_NOMINAL_FPS)-1:0]   day,
   output logic [ftdt_pkg::start_width(MAX_NOMINAL_FPS)-1:0] start_off
);
   import ftdt_pkg::*;

   localparam int NW  = nom_width(MAX_NOMINAL_FPS);
   localparam int MW  = min_width(MAX_NOMINAL_FPS);
   localparam int TW  = ten_width(MAX_NOMINAL_FPS);
   localparam int HW  = hour_width(MAX_NOMINAL_FPS);
   localparam int DW  = day_width(MAX_NOMINAL_FPS);
   localparam int SW  = start_width(MAX_NOMINAL_FPS);
   localparam int QW  = NUM_W + 1;
   localparam int CW  = $clog2(QW);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_CALC1 = 3'd2;
   localparam logic [2:0] ST_CALC2 = 3'd3;
   localparam logic [2:0] ST_IDLE  = 3'd4;

   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [START_W-1:0] start_ff;
   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff;
   logic [QW-1:0]      dvd_ff, quo_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W:0]     r_sh;
   logic               r_hit;
   logic               ok_ff, drop_ff, quad_ff;
   logic [NW-1:0]      nom_ff;
   logic [MW-1:0]      per_min_ff;
   logic [TW-1:0]      per_ten_ff;
   logic [HW-1:0]      per_hour_ff;
   logic [DW-1:0]      day_ff;
   logic [SW-1:0]      start_off_ff;
   logic               csr_write;
   logic               drop_c, quad_c;
   logic [31:0]        nom_c, dpm_c;

   assign csr_ready = pipe_empty;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = (state_ff != ST_IDLE);

   assign r_sh  = {rem_ff, dvd_ff[QW-1]};
   assign r_hit = (r_sh >= {1'b0, den_ff});

   assign drop_c = ((num_ff == NUM_W'(NUM_DROP30)) || (num_ff == NUM_W'(NUM_DROP60))) &&
                   (den_ff == DEN_W'(DEN_DROP));
   assign quad_c = (num_ff == NUM_W'(NUM_DROP60));
   assign nom_c  = 32'(quo_ff);
   assign dpm_c  = quad_c ? 32'(DPM_60) : 32'(DPM_30);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= NUM_W'(NUM_RESET);
         den_ff   <= DEN_W'(DEN_RESET);
         start_ff <= START_W'(START_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM:   num_ff   <= csr_data;
            CSR_DEN:   den_ff   <= csr_data[DEN_W-1:0];
            CSR_START: start_ff <= csr_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   state_in = (cnt_ff == CW'(QW - 1)) ? ST_CALC1 : ST_DIV;
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: state_in = ST_IDLE;
         ST_IDLE:  state_in = ST_IDLE;
         default:  state_in = ST_LOAD;
      endcase
      if (csr_write) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // nominal rate: (num + den/2) / den, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         dvd_ff <= QW'(num_ff) + QW'(den_ff >> 1);
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         rem_ff <= r_hit ? DEN_W'(r_sh - {1'b0, den_ff}) : DEN_W'(r_sh);
         quo_ff <= {quo_ff[QW-2:0], r_hit};
         dvd_ff <= {dvd_ff[QW-2:0], 1'b0};
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC1) begin
         ok_ff <= (num_ff != '0) && (den_ff != '0) && (num_ff <= NUM_W'(NUM_MAX)) &&
                  (den_ff <= DEN_W'(DEN_MAX)) && (quo_ff != '0) &&
                  (quo_ff <= QW'(MAX_NOMINAL_FPS));
         drop_ff     <= drop_c;
         quad_ff     <= quad_c;
         nom_ff      <= NW'(quo_ff);
         per_min_ff  <= MW'(nom_c * 32'(SEC_PER_MIN) - dpm_c);
         per_ten_ff  <= TW'(nom_c * 32'(SEC_PER_TEN) - dpm_c * 32'(DROPS_PER_TEN));
         per_hour_ff <= HW'(nom_c * 32'(SEC_PER_HOUR) - dpm_c * 32'(DROPS_PER_HOUR));
      end
      if (state_ff == ST_CALC2) begin
         if (drop_ff) begin
            day_ff       <= DW'(32'(per_hour_ff) * 32'(HOURS_PER_DAY));
            start_off_ff <= SW'(32'(start_ff) * 32'(per_hour_ff));
         end else begin
            day_ff       <= DW'(32'(nom_ff) * 32'(SEC_PER_DAY));
            start_off_ff <= SW'(32'(start_ff) * 32'(nom_ff) * 32'(SEC_PER_HOUR));
         end
      end
   end

   assign flags.ok   = ok_ff;
   assign flags.drop = drop_ff;
   assign flags.quad = quad_ff;
   assign nom        = nom_ff;
   assign per_min    = per_min_ff;
   assign per_ten    = per_ten_ff;
   assign day        = day_ff;
   assign start_off  = start_off_ff;

endmodule

>>> rtl/frame_to_dropframe_timecode_top.sv
// Pipeline: entry register, one-bit-per-stage day reduction, ten-minute and minute
// division, label re-insertion, seconds division, h/m/s split, output register.
// Throughput: one request per cycle; a stalled result holds the whole pipeline,
// and a pending register write holds off requests. Reset is synchronous, active
// high: 30000/1001 drop-frame, start hour 0. After reset and after each register
// write, req_tready is low while the rate setup (load, nominal-rate divider, calc) runs.
`include "frame_to_dropframe_timecode_top_macros.svh"

module frame_to_dropframe_timecode_top #(
   parameter int MAX_NOMINAL_FPS = ftdt_pkg::MAX_NOMINAL_FPS_DEF,
   parameter int FRAME_BITS      = ftdt_pkg::FRAME_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((FRAME_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // frame_offset
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tc_hours, tc_minutes, tc_seconds, tc_frames
   output logic [ftdt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [ftdt_pkg::RSP_USER_W-1:0]        rsp_tuser,  // drop_mode, rate_invalid
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ftdt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ftdt_pkg::NUM_W-1:0]             csr_data
);
   import ftdt_pkg::*;

   localparam int NW = nom_width(MAX_NOMINAL_FPS);
   localparam int MW = min_width(MAX_NOMINAL_FPS);
   localparam int TW = ten_width(MAX_NOMINAL_FPS);
   localparam int DW = day_width(MAX_NOMINAL_FPS);
   localparam int SW = start_width(MAX_NOMINAL_FPS);
   localparam int FW = FRAME_BITS - 1;
   localparam int XW = ((FW > SW) ? FW : SW) + 1;
   localparam int TQ = TEN_QW;
   localparam int MQ = MIN_QW;
   localparam int SQ = SEC_QW;

   localparam int ST_SUB = XW + TQ + 1;
   localparam int ST_OUT = ST_SUB + MQ + SQ + 6;
   localparam int NST    = ST_OUT + 1;

   rate_flags_type   flags;
   logic             busy;
   logic [NW-1:0]    nom;
   logic [MW-1:0]    per_min;
   logic [TW-1:0]    per_ten;
   logic [DW-1:0]    day;
   logic [SW-1:0]    start_off;
   logic [2:0]       dpm;

   logic [NST-1:0]   vld_ff;
   logic             en;
   logic [FW-1:0]    frame_c;
   logic [XW-1:0]    x_in;

   ftdt_cfg #(
      .MAX_NOMINAL_FPS (MAX_NOMINAL_FPS)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pipe_empty (vld_ff == '0),
      .busy       (busy),
      .flags      (flags),
      .nom        (nom),
      .per_min    (per_min),
      .per_ten    (per_ten),
      .day        (day),
      .start_off  (start_off)
   );

   assign dpm        = flags.quad ? 3'(DPM_60) : 3'(DPM_30);
   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en && !busy && !csr_valid;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid && req_tready};
      end
   end

   // entry: clamp and add timeline start
   assign frame_c = req_tdata[FW] ? '0 : req_tdata[FW-1:0];
   assign x_in    = XW'(frame_c) + XW'(start_off);

   logic [XW-1:0] mx_ff [0:XW-1];
   logic [DW-1:0] mr_ff [0:XW];

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff[0] <= x_in;
         mr_ff[0] <= '0;
      end
   end

   // reduce modulo one day, one bit a stage
   for (genvar k = 1; k <= XW; k++) begin : g_mod
      logic [DW:0] r_sh;
      logic [DW:0] r_sub;
      assign r_sh  = {mr_ff[k-1], mx_ff[k-1][XW-k]};
      assign r_sub = r_sh - {1'b0, day};
      always_ff @(posedge clock) begin
         if (en) begin
            mr_ff[k] <= (r_sh >= {1'b0, day}) ? r_sub[DW-1:0] : r_sh[DW-1:0];
         end
      end
      if (k < XW) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               mx_ff[k] <= mx_ff[k-1];
            end
         end
      end
   end

   // ten-minute blocks
   logic [DW-1:0] ty_ff [0:TQ-1];
   logic [DW-1:0] tr_ff [0:TQ-1];
   logic [TQ-1:0] tq_ff [0:TQ-1];

   for (genvar j = 0; j < TQ; j++) begin : g_ten
      logic [DW-1:0]    y_s, r_s;
      logic [TQ-1:0]    q_s;
      logic [DW+TQ-1:0] dsh;
      logic             hit;
      if (j == 0) begin : g_first
         assign y_s = mr_ff[XW];
         assign r_s = mr_ff[XW];
         assign q_s = '0;
      end else begin : g_next
         assign y_s = ty_ff[j-1];
         assign r_s = tr_ff[j-1];
         assign q_s = tq_ff[j-1];
      end
      assign dsh = (DW+TQ)'(per_ten) << (TQ - 1 - j);
      assign hit = ((DW+TQ)'(r_s) >= dsh);
      always_ff @(posedge clock) begin
         if (en) begin
            ty_ff[j] <= y_s;
            tr_ff[j] <= hit ? DW'((DW+TQ)'(r_s) - dsh) : r_s;
            tq_ff[j] <= q_s | (hit ? (TQ'(1) << (TQ - 1 - j)) : '0);
         end
      end
   end

   logic [DW-1:0] sy_ff;
   logic [TQ-1:0] sb_ff;
   logic [TW-1:0] st_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sy_ff <= ty_ff[TQ-1];
         sb_ff <= tq_ff[TQ-1];
         st_ff <= (tr_ff[TQ-1] >= DW'(dpm)) ? TW'(tr_ff[TQ-1] - DW'(dpm)) : '0;
      end
   end

   // minutes within the block
   logic [DW-1:0] my_ff [0:MQ-1];
   logic [TQ-1:0] mb_ff [0:MQ-1];
   logic [TW-1:0] mt_ff [0:MQ-1];
   logic [MQ-1:0] mq_ff [0:MQ-1];

   for (genvar j = 0; j < MQ; j++) begin : g_min
      logic [DW-1:0]    y_s;
      logic [TQ-1:0]    b_s;
      logic [TW-1:0]    t_s;
      logic [MQ-1:0]    q_s;
      logic [TW+MQ-1:0] dsh;
      logic             hit;
      if (j == 0) begin : g_first
         assign y_s = sy_ff;
         assign b_s = sb_ff;
         assign t_s = st_ff;
         assign q_s = '0;
      end else begin : g_next
         assign y_s = my_ff[j-1];
         assign b_s = mb_ff[j-1];
         assign t_s = mt_ff[j-1];
         assign q_s = mq_ff[j-1];
      end
      assign dsh = (TW+MQ)'(per_min) << (MQ - 1 - j);
      assign hit = ((TW+MQ)'(t_s) >= dsh);
      always_ff @(posedge clock) begin
         if (en) begin
            my_ff[j] <= y_s;
            mb_ff[j] <= b_s;
            mt_ff[j] <= hit ? TW'((TW+MQ)'(t_s) - dsh) : t_s;
            mq_ff[j] <= q_s | (hit ? (MQ'(1) << (MQ - 1 - j)) : '0);
         end
      end
   end

   // put the skipped labels back
   logic [DW-1:0] af_ff;
   logic [DW-1:0] add_blk, add_min;

   assign add_blk = DW'(32'(dpm) * 32'(DROPS_PER_TEN) * 32'(mb_ff[MQ-1]));
   assign add_min = DW'(32'(dpm) * 32'(mq_ff[MQ-1]));

   always_ff @(posedge clock) begin
      if (en) begin
         af_ff <= flags.drop ? (my_ff[MQ-1] + add_blk + add_min) : my_ff[MQ-1];
      end
   end

   // seconds and frame label
   logic [DW-1:0] cr_ff [0:SQ-1];
   logic [SQ-1:0] cq_ff [0:SQ-1];

   for (genvar j = 0; j < SQ; j++) begin : g_sec
      logic [DW-1:0]    r_s;
      logic [SQ-1:0]    q_s;
      logic [DW+SQ-1:0] dsh;
      logic             hit;
      if (j == 0) begin : g_first
         assign r_s = af_ff;
         assign q_s = '0;
      end else begin : g_next
         assign r_s = cr_ff[j-1];
         assign q_s = cq_ff[j-1];
      end
      assign dsh = (DW+SQ)'(nom) << (SQ - 1 - j);
      assign hit = ((DW+SQ)'(r_s) >= dsh);
      always_ff @(posedge clock) begin
         if (en) begin
            cr_ff[j] <= hit ? DW'((DW+SQ)'(r_s) - dsh) : r_s;
            cq_ff[j] <= q_s | (hit ? (SQ'(1) << (SQ - 1 - j)) : '0);
         end
      end
   end

   // split seconds into h/m/s
   logic [SQ-1:0]   h1s_ff;
   logic [NW-1:0]   h1f_ff, h2f_ff, m1f_ff, m2f_ff;
   logic [HR_W-1:0] h1q_ff, h2q_ff, m1h_ff, m2h_ff;
   logic [SQ-1:0]   h_rem;
   logic [SR_W-1:0] h2r_ff, m1r_ff;
   logic [MN_W-1:0] m1q_ff, m2q_ff;
   logic [SR_W-1:0] m_rem;
   logic [MN_W-1:0] m2s_ff;

   assign h_rem = h1s_ff - SQ'(32'(h1q_ff) * 32'(SEC_PER_HOUR));
   assign m_rem = m1r_ff - SR_W'(32'(m1q_ff) * 32'(SEC_PER_MIN));

   always_ff @(posedge clock) begin
      if (en) begin
         h1s_ff <= cq_ff[SQ-1];
         h1f_ff <= NW'(cr_ff[SQ-1]);
         h1q_ff <= HR_W'((32'(cq_ff[SQ-1]) * 32'(RECIP_HOUR)) >> RECIP_HOUR_SH);

         h2f_ff <= h1f_ff;
         if (h_rem >= SQ'(SEC_PER_HOUR)) begin
            h2q_ff <= h1q_ff + HR_W'(1);
            h2r_ff <= SR_W'(h_rem - SQ'(SEC_PER_HOUR));
         end else begin
            h2q_ff <= h1q_ff;
            h2r_ff <= SR_W'(h_rem);
         end

         m1f_ff <= h2f_ff;
         m1h_ff <= h2q_ff;
         m1r_ff <= h2r_ff;
         m1q_ff <= MN_W'((32'(h2r_ff) * 32'(RECIP_MIN)) >> RECIP_MIN_SH);

         m2f_ff <= m1f_ff;
         m2h_ff <= m1h_ff;
         if (m_rem >= SR_W'(SEC_PER_MIN)) begin
            m2q_ff <= m1q_ff + MN_W'(1);
            m2s_ff <= MN_W'(m_rem - SR_W'(SEC_PER_MIN));
         end else begin
            m2q_ff <= m1q_ff;
            m2s_ff <= MN_W'(m_rem);
         end
      end
   end

   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_USER_W-1:0] out_user_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (flags.ok) begin
            out_data_ff <= {7'd0, 8'(m2f_ff), m2s_ff, m2q_ff, 5'(m2h_ff)};
            out_user_ff <= {1'b0, flags.drop};
         end else begin
            out_data_ff <= '0;
            out_user_ff <= 2'b10;
         end
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

   `FTDT_ASSERT(a_tc_range, rsp_tvalid && !rsp_tuser[1], rsp_tdata[4:0] < 5'd24 && rsp_tdata[10:5] < 6'd60 && rsp_tdata[16:11] < 6'd60, "timecode field out of range")
   `FTDT_ASSERT(a_invalid_zero, rsp_tvalid && rsp_tuser[1], rsp_tdata == '0 && !rsp_tuser[0], "invalid rate with nonzero timecode")
   `FTDT_ASSERT(a_drop_skip, rsp_tvalid && rsp_tuser[0] && rsp_tdata[16:11] == 6'd0 && rsp_tdata[24:17] < 8'd2, rsp_tdata[10:5] == 6'd0 || rsp_tdata[10:5] == 6'd10 || rsp_tdata[10:5] == 6'd20 || rsp_tdata[10:5] == 6'd30 || rsp_tdata[10:5] == 6'd40 || rsp_tdata[10:5] == 6'd50, "dropped label emitted")
   `FTDT_ASSERT_NEXT(a_csr_setup, csr_valid && csr_ready, busy && !req_tready, "register write without rate setup")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ftdt_pkg::*;

   localparam int FB = FRAME_BITS_DEF;
   localparam int LATENCY = FB + 37;
   localparam int TIMEOUT_CYCLES = 400000;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic [7:0] frames;
      logic       drop;
      logic       invalid;
   } timecode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [NUM_W-1:0] csr_data = '0;

   frame_to_dropframe_timecode_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [39:0]  offset_queue[$];
   timecode_type timecode_queue[$];
   longint unsigned rate_num = NUM_RESET;
   longint unsigned rate_den = DEN_RESET;
   longint unsigned start_hr = START_RESET;
   int errors = 0;
   int cycles = 0;
   bit hold_off = 1'b0;
   bit quiet = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   function automatic timecode_type convert_offset(input logic [39:0] raw);
      timecode_type tc;
      longint unsigned nom, frame, secs, dpm, per_min, per_ten, per_hour, blocks, rem;
      bit drop;
      tc = '0;
      nom = 0;
      if (rate_num != 0 && rate_den != 0 && rate_num <= NUM_MAX && rate_den <= DEN_MAX)
         nom = (rate_num + rate_den / 2) / rate_den;
      if (nom == 0 || nom > MAX_NOMINAL_FPS_DEF) begin
         tc.invalid = 1'b1;
         return tc;
      end
      frame = raw[39] ? 0 : longint'(raw);
      drop = (rate_num == NUM_DROP30 || rate_num == NUM_DROP60) && rate_den == DEN_DROP;
      if (drop) begin
         dpm = (nom == 60) ? DPM_60 : DPM_30;
         per_min = nom * 60 - dpm;
         per_ten = nom * 600 - dpm * 9;
         per_hour = nom * 3600 - dpm * 54;
         frame = (frame + start_hr * per_hour) % (per_hour * 24);
         blocks = frame / per_ten;
         rem = frame % per_ten;
         frame += dpm * 9 * blocks;
         if (rem >= dpm)
            frame += dpm * ((rem - dpm) / per_min);
      end else begin
         frame += start_hr * nom * 3600;
      end
      secs = frame / nom;
      tc.hours = 5'((secs / 3600) % 24);
      tc.minutes = 6'((secs / 60) % 60);
      tc.seconds = 6'(secs % 60);
      tc.frames = 8'(frame % nom);
      tc.drop = drop;
      return tc;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("error at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
   endtask

   // request driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            timecode_queue.insert(timecode_queue.size(), convert_offset(req_tdata));
            void'(offset_queue.pop_front());
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && !(req_tvalid && !req_tready) &&
                      $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 11);
            req_tvalid <= 1'b0;
         end else begin
            int n;
            n = (req_tvalid && req_tready) ? 1 : 0;
            if (!hold_off && offset_queue.size() > n) begin
               req_tvalid <= 1'b1;
               req_tdata <= offset_queue[n];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            timecode_type got, want;
            got = {rsp_tdata[24:0], rsp_tuser[0], rsp_tuser[1]};
            got.hours = rsp_tdata[4:0];
            got.minutes = rsp_tdata[10:5];
            got.seconds = rsp_tdata[16:11];
            got.frames = rsp_tdata[24:17];
            got.drop = rsp_tuser[0];
            got.invalid = rsp_tuser[1];
            if (timecode_queue.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               want = timecode_queue.pop_front();
               if (got.hours !== want.hours) report("tc_hours", got.hours, want.hours);
               if (got.minutes !== want.minutes)
                  report("tc_minutes", got.minutes, want.minutes);
               if (got.seconds !== want.seconds)
                  report("tc_seconds", got.seconds, want.seconds);
               if (got.frames !== want.frames) report("tc_frames", got.frames, want.frames);
               if (got.drop !== want.drop) report("drop_mode", got.drop, want.drop);
               if (got.invalid !== want.invalid)
                  report("rate_invalid", got.invalid, want.invalid);
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > TIMEOUT_CYCLES) begin
         $display("frame_to_dropframe_timecode_top: mismatch");
         $finish;
      end
   end

   task automatic drain();
      while (offset_queue.size() != 0 || req_tvalid || timecode_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input longint unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= NUM_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM: rate_num = value & 18'h3FFFF;
         CSR_DEN: rate_den = value & 14'h3FFF;
         default: start_hr = value & 5'h1F;
      endcase
   endtask

   function automatic logic [39:0] random_offset();
      case ($urandom_range(0, 5))
         0: return 40'($urandom_range(0, 3000));
         1: return 40'($urandom_range(0, 5200000));
         2: return 40'({$urandom, $urandom});
         3: return 40'(-longint'($urandom_range(1, 1000)));
         4: return 40'(longint'($urandom_range(0, 1000)) * 17982 + $urandom_range(0, 5));
         default: return 40'(longint'($urandom_range(0, 1000)) * 1798 + $urandom_range(0, 5));
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) offset_queue.insert(offset_queue.size(), random_offset());
   endtask

   initial begin
      logic [39:0] directed[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed = '{40'd0, 40'd1, 40'd2, 40'd1799, 40'd1800, 40'd17981, 40'd17982,
                   40'd107891, 40'd107892, 40'd2589407, 40'd2589408, 40'h7F_FFFF_FFFF,
                   40'h80_0000_0000, 40'hFF_FFFF_FFFF, 40'hAA_AAAA_AAAA, 40'h55_5555_5555};
      foreach (directed[k]) offset_queue.insert(offset_queue.size(), directed[k]);
      send_random(200);
      // pause until everything has come back
      while (offset_queue.size() != 0) @(posedge clock);
      hold_off = 1'b1;
      while (timecode_queue.size() != 0 || req_tvalid) @(posedge clock);
      hold_off = 1'b0;
      write_reg(CSR_NUM, NUM_DROP60);
      write_reg(CSR_START, 23);
      foreach (directed[k]) offset_queue.insert(offset_queue.size(), directed[k]);
      send_random(200);
      write_reg(CSR_START, 31);
      send_random(150);
      write_reg(CSR_NUM, 24);
      write_reg(CSR_DEN, 1);
      send_random(150);
      write_reg(CSR_NUM, 240000);
      write_reg(CSR_DEN, 1000);
      send_random(150);
      write_reg(CSR_DEN, 999);
      send_random(30);
      write_reg(CSR_NUM, 0);
      send_random(30);
      write_reg(CSR_NUM, 262143);
      write_reg(CSR_DEN, 16383);
      send_random(30);
      write_reg(CSR_DEN, 0);
      send_random(30);
      write_reg(CSR_NUM, 1);
      write_reg(CSR_DEN, 10000);
      send_random(30);
      write_reg(CSR_NUM, 25);
      write_reg(CSR_DEN, 1);
      write_reg(CSR_START, 7);
      send_random(200);
      write_reg(CSR_NUM, 30000);
      write_reg(CSR_DEN, 1001);
      write_reg(CSR_START, 0);
      send_random(250);
      write_reg(CSR_NUM, 60000);
      send_random(200);
      write_reg(CSR_NUM, 30000);
      write_reg(CSR_START, 12);
      quiet = 1'b1;
      send_random(200);
      drain();
      if (errors == 0) begin
         $display("frame_to_dropframe_timecode_top: match");
      end else begin
         $display("frame_to_dropframe_timecode_top: mismatch");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ftdt_pkg.sv
rtl/ftdt_cfg.sv
rtl/frame_to_dropframe_timecode_top.sv
bench/testbench.sv
